// ===== hw/rtl/vgvq_pkg.sv =====
`default_nettype none
package vgvq_pkg;

  localparam int CFG_W   = 7;
  localparam int INV_W   = 20;
  localparam int SIZE_W  = 11;
  localparam int COORD_W = 10;
  localparam int LAG_W   = 21;
  localparam int IDX_W   = 18;
  localparam int VEL_W   = 22;
  localparam int CELL_W  = 3 * VEL_W;
  localparam int OUT_W   = 32;
  localparam int MAG_W   = 22;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;

  // stencil read order: center, then low and high neighbor along x, y, z
  localparam logic [2:0] NB_CTR   = 3'd0;
  localparam logic [2:0] NB_XM    = 3'd1;
  localparam logic [2:0] NB_XP    = 3'd2;
  localparam logic [2:0] NB_YM    = 3'd3;
  localparam logic [2:0] NB_YP    = 3'd4;
  localparam logic [2:0] NB_ZM    = 3'd5;
  localparam logic [2:0] NB_ZP    = 3'd6;
  localparam logic [2:0] NB_COUNT = 3'd7;

  // multiplier schedule
  localparam logic [4:0] ST_GRAD0 = 5'd0;
  localparam logic [4:0] ST_Q0    = 5'd9;
  localparam logic [4:0] ST_QNEG0 = 5'd12;
  localparam logic [4:0] ST_VEL0  = 5'd15;
  localparam logic [4:0] ST_VORT0 = 5'd18;
  localparam logic [4:0] ST_LAST  = 5'd20;

  typedef enum logic [1:0] {
    REG_SIZE_X     = 2'd0,
    REG_SIZE_Y     = 2'd1,
    REG_SIZE_Z     = 2'd2,
    REG_INV_TWO_DX = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_MUL,
    B_SQ_VEL,
    B_SQ_VORT,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic [IDX_W-1:0]   cell_index;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [1:0]         zs;
    logic [2:0]         lo_face;
    logic [2:0]         hi_face;
    logic               two_d;
    logic               last;
  } job_t;

  function automatic logic signed [OUT_W-1:0] sat32_f(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[OUT_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vgvq_store.sv =====
`default_nettype none
module vgvq_store #(
  parameter int DEPTH  = 12288,
  parameter int MEM_AW = 14
) (
  input  wire                       clk,
  input  wire                       wr_en,
  input  wire  [MEM_AW-1:0]         wr_addr,
  input  wire  [vgvq_pkg::CELL_W-1:0] wr_data,
  input  wire                       rd_en,
  input  wire  [MEM_AW-1:0]         rd_addr,
  output logic [vgvq_pkg::CELL_W-1:0] rd_data_r
);
  import vgvq_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/vgvq_fifo.sv =====
`default_nettype none
module vgvq_fifo (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  vgvq_pkg::job_t     push_job,
  input  wire                pop,
  output vgvq_pkg::job_t     head,
  output logic               full,
  output logic               empty
);
  import vgvq_pkg::*;

  job_t       ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign head  = ent_r[rp_r];
  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = ~wp_r;
    end
    if (pop) begin
      rp_nxt = ~rp_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/vgvq_front.sv =====
`default_nettype none
module vgvq_front #(
  parameter int MAX_X  = 64,
  parameter int MAX_Y  = 64,
  parameter int MEM_AW = 14
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          restart,
  input  wire  [vgvq_pkg::SIZE_W-1:0]  sx,
  input  wire  [vgvq_pkg::SIZE_W-1:0]  sy,
  input  wire  [vgvq_pkg::SIZE_W-1:0]  sz,
  input  wire  [vgvq_pkg::LAG_W-1:0]   lag,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          in_kind,
  input  wire  [vgvq_pkg::VEL_W-1:0]   in_vel_x,
  input  wire  [vgvq_pkg::VEL_W-1:0]   in_vel_y,
  input  wire  [vgvq_pkg::VEL_W-1:0]   in_vel_z,
  output logic                         wr_en,
  output logic [MEM_AW-1:0]            wr_addr,
  output logic [vgvq_pkg::CELL_W-1:0]  wr_data,
  output logic                         push,
  output vgvq_pkg::job_t               push_job,
  input  wire                          q_full,
  input  wire                          q_empty,
  input  wire                          back_idle
);
  import vgvq_pkg::*;

  localparam int PLANE = MAX_X * MAX_Y;

  logic [COORD_W-1:0] ix_r, ix_nxt, iy_r, iy_nxt, iz_r, iz_nxt;
  logic [1:0]         izs_r, izs_nxt;
  logic [COORD_W-1:0] ox_r, ox_nxt, oy_r, oy_nxt, oz_r, oz_nxt;
  logic [1:0]         ozs_r, ozs_nxt;
  logic [IDX_W-1:0]   cur_r, cur_nxt;
  logic [LAG_W-1:0]   ahead_r, ahead_nxt;
  logic               done_r, done_nxt;
  logic               hold_r, hold_nxt;

  logic               accept, is_cell, is_drain;
  logic               iwx, iwy, iwz, owx, owy, owz;
  logic [LAG_W-1:0]   ahead_inc;

  assign in_ready = !q_full && !hold_r;
  assign accept   = in_valid && in_ready;
  assign is_cell  = accept && !in_kind && !done_r;
  assign is_drain = accept && in_kind && done_r;

  assign iwx = (SIZE_W'(ix_r) == sx - SIZE_W'(1));
  assign iwy = (SIZE_W'(iy_r) == sy - SIZE_W'(1));
  assign iwz = (SIZE_W'(iz_r) == sz - SIZE_W'(1));
  assign owx = (SIZE_W'(ox_r) == sx - SIZE_W'(1));
  assign owy = (SIZE_W'(oy_r) == sy - SIZE_W'(1));
  assign owz = (SIZE_W'(oz_r) == sz - SIZE_W'(1));

  assign ahead_inc = ahead_r + LAG_W'(1);

  assign wr_en   = is_cell;
  assign wr_addr = MEM_AW'(int'(izs_r) * PLANE + int'(iy_r) * MAX_X + int'(ix_r));
  assign wr_data = {in_vel_z, in_vel_y, in_vel_x};

  assign push = (is_cell && (ahead_inc > lag)) || is_drain;

  always_comb begin
    push_job.cell_index = cur_r;
    push_job.x          = ox_r;
    push_job.y          = oy_r;
    push_job.zs         = ozs_r;
    push_job.lo_face    = {oz_r == '0, oy_r == '0, ox_r == '0};
    push_job.hi_face    = {owz, owy, owx};
    push_job.two_d      = (sz == SIZE_W'(1));
    push_job.last       = owx && owy && owz;
  end

  always_comb begin
    ix_nxt    = ix_r;
    iy_nxt    = iy_r;
    iz_nxt    = iz_r;
    izs_nxt   = izs_r;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    oz_nxt    = oz_r;
    ozs_nxt   = ozs_r;
    cur_nxt   = cur_r;
    ahead_nxt = ahead_r;
    done_nxt  = done_r;
    hold_nxt  = hold_r;

    // the last few results may still read the final planes: new cells wait
    if (hold_r && q_empty && back_idle) begin
      hold_nxt = 1'b0;
    end

    if (is_cell) begin
      ix_nxt = ix_r + COORD_W'(1);
      if (iwx) begin
        ix_nxt = '0;
        iy_nxt = iy_r + COORD_W'(1);
        if (iwy) begin
          iy_nxt  = '0;
          iz_nxt  = iz_r + COORD_W'(1);
          izs_nxt = (izs_r == 2'd2) ? 2'd0 : izs_r + 2'd1;
          if (iwz) begin
            iz_nxt   = '0;
            izs_nxt  = 2'd0;
            done_nxt = 1'b1;
          end
        end
      end
      if (!push) begin
        ahead_nxt = ahead_inc;
      end
    end else if (is_drain) begin
      ahead_nxt = ahead_r - LAG_W'(1);
    end

    if (push) begin
      cur_nxt = cur_r + IDX_W'(1);
      ox_nxt  = ox_r + COORD_W'(1);
      if (owx) begin
        ox_nxt = '0;
        oy_nxt = oy_r + COORD_W'(1);
        if (owy) begin
          oy_nxt  = '0;
          oz_nxt  = oz_r + COORD_W'(1);
          ozs_nxt = (ozs_r == 2'd2) ? 2'd0 : ozs_r + 2'd1;
        end
      end
    end

    if ((is_drain && push_job.last) || restart) begin
      ix_nxt    = '0;
      iy_nxt    = '0;
      iz_nxt    = '0;
      izs_nxt   = 2'd0;
      ox_nxt    = '0;
      oy_nxt    = '0;
      oz_nxt    = '0;
      ozs_nxt   = 2'd0;
      cur_nxt   = '0;
      ahead_nxt = '0;
      done_nxt  = 1'b0;
      hold_nxt  = !restart;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ix_r    <= '0;
      iy_r    <= '0;
      iz_r    <= '0;
      izs_r   <= 2'd0;
      ox_r    <= '0;
      oy_r    <= '0;
      oz_r    <= '0;
      ozs_r   <= 2'd0;
      cur_r   <= '0;
      ahead_r <= '0;
      done_r  <= 1'b0;
      hold_r  <= 1'b0;
    end else begin
      ix_r    <= ix_nxt;
      iy_r    <= iy_nxt;
      iz_r    <= iz_nxt;
      izs_r   <= izs_nxt;
      ox_r    <= ox_nxt;
      oy_r    <= oy_nxt;
      oz_r    <= oz_nxt;
      ozs_r   <= ozs_nxt;
      cur_r   <= cur_nxt;
      ahead_r <= ahead_nxt;
      done_r  <= done_nxt;
      hold_r  <= hold_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/vgvq_isqrt.sv =====
`default_nettype none
module vgvq_isqrt (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  input  wire  [63:0] din,
  output logic        done_r,
  output logic [31:0] root_r
);
  import vgvq_pkg::*;

  logic [63:0] op_r;
  logic [34:0] rem_r;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_nxt;
  logic [34:0] t, trial;
  logic        fits;

  // one result bit per cycle, two operand bits shifted in
  assign t     = {rem_r[32:0], op_r[63:62]};
  assign trial = {1'b0, root_r, 2'b01};
  assign fits  = (t >= trial);

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 5'd0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r   <= din;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      op_r   <= {op_r[61:0], 2'b00};
      rem_r  <= fits ? t - trial : t;
      root_r <= {root_r[30:0], fits};
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/vgvq_back.sv =====
`default_nettype none
module vgvq_back #(
  parameter int MAX_X     = 64,
  parameter int MAX_Y     = 64,
  parameter int MEM_AW    = 14,
  parameter int FRAC_BITS = 20
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire  [vgvq_pkg::INV_W-1:0]         inv_two_dx,
  input  wire                                job_avail,
  input  vgvq_pkg::job_t                     job,
  output logic                               pop,
  output logic                               rd_en,
  output logic [MEM_AW-1:0]                  rd_addr,
  input  wire  [vgvq_pkg::CELL_W-1:0]        rd_data,
  output logic                               idle,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [vgvq_pkg::IDX_W-1:0]         out_cell_index,
  output logic signed [vgvq_pkg::OUT_W-1:0]  out_vort_x,
  output logic signed [vgvq_pkg::OUT_W-1:0]  out_vort_y,
  output logic signed [vgvq_pkg::OUT_W-1:0]  out_vort_z,
  output logic [vgvq_pkg::MAG_W-1:0]         out_vel_mag,
  output logic [vgvq_pkg::OUT_W-1:0]         out_vort_mag,
  output logic signed [vgvq_pkg::OUT_W-1:0]  out_q_value,
  output logic                               out_last
);
  import vgvq_pkg::*;

  localparam int PLANE = MAX_X * MAX_Y;

  back_state_t state_r, state_nxt;
  logic [2:0]  rd_step_r, rd_step_nxt;
  logic [4:0]  st_r, st_nxt;
  logic        ph_r, ph_nxt;
  logic        out_valid_r, out_valid_nxt;

  job_t                     job_r;
  logic [CELL_W-1:0]        cell_r [7];
  logic signed [OUT_W-1:0]  g_r [9];
  logic signed [65:0]       p_r;
  logic signed [63:0]       q_acc_r;
  logic [43:0]              vsum_r;
  logic [63:0]              wsum_r;
  logic [MAG_W-1:0]         vmag_r;

  logic                     sq_start, sq_done;
  logic [63:0]              sq_din;
  logic [31:0]              sq_root;
  logic                     load_out;

  // stencil address
  logic [COORD_W-1:0] ax, ay;
  logic [1:0]         azs;

  always_comb begin
    ax  = job_r.x;
    ay  = job_r.y;
    azs = job_r.zs;
    case (rd_step_r)
      NB_XM: if (!job_r.lo_face[0]) ax = job_r.x - COORD_W'(1);
      NB_XP: if (!job_r.hi_face[0]) ax = job_r.x + COORD_W'(1);
      NB_YM: if (!job_r.lo_face[1]) ay = job_r.y - COORD_W'(1);
      NB_YP: if (!job_r.hi_face[1]) ay = job_r.y + COORD_W'(1);
      NB_ZM: if (!job_r.lo_face[2]) azs = (job_r.zs == 2'd0) ? 2'd2 : job_r.zs - 2'd1;
      NB_ZP: if (!job_r.hi_face[2]) azs = (job_r.zs == 2'd2) ? 2'd0 : job_r.zs + 2'd1;
      default: ;
    endcase
  end

  assign rd_addr = MEM_AW'(int'(azs) * PLANE + int'(ay) * MAX_X + int'(ax));

  // one central difference, chosen by the multiplier step
  logic [1:0]                comp, axis;
  logic signed [VEL_W-1:0]   c_v, lo_v, hi_v;
  logic signed [VEL_W+1:0]   d;
  logic [2:0]                lo_idx, hi_idx;

  always_comb begin
    if (st_r >= 5'd6) begin
      comp = 2'd2;
    end else if (st_r >= 5'd3) begin
      comp = 2'd1;
    end else begin
      comp = 2'd0;
    end
    axis   = 2'(st_r - 5'(3 * int'(comp)));
    lo_idx = 3'(1 + 2 * int'(axis));
    hi_idx = 3'(2 + 2 * int'(axis));
    c_v    = $signed(cell_r[NB_CTR][comp * VEL_W +: VEL_W]);
    lo_v   = $signed(cell_r[lo_idx][comp * VEL_W +: VEL_W]);
    hi_v   = $signed(cell_r[hi_idx][comp * VEL_W +: VEL_W]);
    if (axis == 2'd2 && job_r.two_d) begin
      d = '0;
    end else if (job_r.lo_face[axis]) begin
      d = ((VEL_W+2)'(hi_v) - (VEL_W+2)'(c_v)) <<< 1;
    end else if (job_r.hi_face[axis]) begin
      d = ((VEL_W+2)'(c_v) - (VEL_W+2)'(lo_v)) <<< 1;
    end else begin
      d = (VEL_W+2)'(hi_v) - (VEL_W+2)'(lo_v);
    end
  end

  // vorticity from the saturated gradient terms, g index is 3*component+axis
  logic signed [OUT_W:0]   dvx, dvy, dvz;
  logic signed [OUT_W-1:0] vx, vy, vz;

  assign dvx = (OUT_W+1)'(g_r[7]) - (OUT_W+1)'(g_r[5]);
  assign dvy = (OUT_W+1)'(g_r[2]) - (OUT_W+1)'(g_r[6]);
  assign dvz = (OUT_W+1)'(g_r[3]) - (OUT_W+1)'(g_r[1]);
  assign vx  = sat32_f(64'(dvx));
  assign vy  = sat32_f(64'(dvy));
  assign vz  = sat32_f(64'(dvz));

  // shared multiplier operands
  logic signed [32:0] opa, opb;
  logic [1:0]         vc;

  assign vc = 2'(st_r - ST_VEL0);

  always_comb begin
    opa = 33'(d);
    opb = $signed({13'b0, inv_two_dx});
    case (st_r)
      5'd9:  begin opa = 33'(g_r[0]); opb = 33'(g_r[4]); end
      5'd10: begin opa = 33'(g_r[4]); opb = 33'(g_r[8]); end
      5'd11: begin opa = 33'(g_r[8]); opb = 33'(g_r[0]); end
      5'd12: begin opa = 33'(g_r[1]); opb = 33'(g_r[3]); end
      5'd13: begin opa = 33'(g_r[5]); opb = 33'(g_r[7]); end
      5'd14: begin opa = 33'(g_r[6]); opb = 33'(g_r[2]); end
      5'd15, 5'd16, 5'd17: begin
        opa = 33'($signed(cell_r[NB_CTR][vc * VEL_W +: VEL_W]));
        opb = opa;
      end
      5'd18: begin opa = 33'(vx); opb = 33'(vx); end
      5'd19: begin opa = 33'(vy); opb = 33'(vy); end
      5'd20: begin opa = 33'(vz); opb = 33'(vz); end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    rd_step_nxt = rd_step_r;
    st_nxt      = st_r;
    ph_nxt      = ph_r;
    pop         = 1'b0;
    rd_en       = 1'b0;
    sq_start    = 1'b0;
    sq_din      = {20'b0, vsum_r};
    load_out    = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (job_avail) begin
          pop         = 1'b1;
          rd_step_nxt = 3'd0;
          state_nxt   = B_READ;
        end
      end
      B_READ: begin
        rd_en       = (rd_step_r < NB_COUNT);
        rd_step_nxt = rd_step_r + 3'd1;
        if (rd_step_r == NB_COUNT) begin
          st_nxt    = ST_GRAD0;
          ph_nxt    = 1'b0;
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          if (st_r == ST_LAST) begin
            sq_start  = 1'b1;
            state_nxt = B_SQ_VEL;
          end else begin
            st_nxt = st_r + 5'd1;
          end
        end
      end
      B_SQ_VEL: begin
        if (sq_done) begin
          sq_start  = 1'b1;
          sq_din    = wsum_r;
          state_nxt = B_SQ_VORT;
        end
      end
      B_SQ_VORT: begin
        if (sq_done) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      rd_step_r   <= 3'd0;
      st_r        <= 5'd0;
      ph_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_step_r   <= rd_step_nxt;
      st_r        <= st_nxt;
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= job;
    end
    if (state_r == B_READ && rd_step_r != NB_CTR) begin
      cell_r[rd_step_r - 3'd1] <= rd_data;
    end
    p_r <= opa * opb;
    if (state_r == B_READ) begin
      q_acc_r <= '0;
      vsum_r  <= '0;
      wsum_r  <= '0;
    end else if (state_r == B_MUL && ph_r) begin
      if (st_r < ST_Q0) begin
        g_r[st_r[3:0]] <= sat32_f(64'(p_r >>> 8));
      end else if (st_r < ST_QNEG0) begin
        q_acc_r <= q_acc_r + 64'(p_r >>> FRAC_BITS);
      end else if (st_r < ST_VEL0) begin
        q_acc_r <= q_acc_r - 64'(p_r >>> FRAC_BITS);
      end else if (st_r < ST_VORT0) begin
        vsum_r <= vsum_r + p_r[43:0];
      end else begin
        wsum_r <= wsum_r + p_r[63:0];
      end
    end
    if (state_r == B_SQ_VEL && sq_done) begin
      vmag_r <= (sq_root > 32'h003FFFFF) ? {MAG_W{1'b1}} : sq_root[MAG_W-1:0];
    end
    if (load_out) begin
      out_cell_index <= job_r.cell_index;
      out_vort_x     <= vx;
      out_vort_y     <= vy;
      out_vort_z     <= vz;
      out_vel_mag    <= vmag_r;
      out_vort_mag   <= sq_root;
      out_q_value    <= sat32_f(q_acc_r);
      out_last       <= job_r.last;
    end
  end

  assign idle      = (state_r == B_IDLE);
  assign out_valid = out_valid_r;

  vgvq_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sq_start),
    .din    (sq_din),
    .done_r (sq_done),
    .root_r (sq_root)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/velocity_gradient_vorticity_q.sv =====
`default_nettype none
// Streams velocity cells (kind 0) in raster order, x fastest, into a three-plane
// store and returns per cell the vorticity vector, the velocity and vorticity
// magnitudes and the Q invariant. A result comes out one plane after its cell
// (one row in 2-D mode, size_z = 1); once the volume is in, each drain request
// (kind 1) flushes one pending result. The input side takes one request per
// cycle until the two-entry job queue is full; the back end then works on one
// result at a time: 7 store reads, 21 products on one shared 33x33 multiplier
// and two bit-serial square roots. After the final result of a volume, new
// cells wait until the back end has emptied. Size writes restart the volume;
// the store needs no clearing pass.
module velocity_gradient_vorticity_q #(
  parameter int MAX_X     = 64,
  parameter int MAX_Y     = 64,
  parameter int MAX_Z     = 64,
  parameter int FRAC_BITS = 20
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire                                in_kind,
  input  wire  signed [vgvq_pkg::VEL_W-1:0]  in_vel_x,
  input  wire  signed [vgvq_pkg::VEL_W-1:0]  in_vel_y,
  input  wire  signed [vgvq_pkg::VEL_W-1:0]  in_vel_z,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [vgvq_pkg::IDX_W-1:0]         out_cell_index,
  output logic signed [vgvq_pkg::OUT_W-1:0]  out_vort_x,
  output logic signed [vgvq_pkg::OUT_W-1:0]  out_vort_y,
  output logic signed [vgvq_pkg::OUT_W-1:0]  out_vort_z,
  output logic [vgvq_pkg::MAG_W-1:0]         out_vel_mag,
  output logic [vgvq_pkg::OUT_W-1:0]         out_vort_mag,
  output logic signed [vgvq_pkg::OUT_W-1:0]  out_q_value,
  output logic                               out_last,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [vgvq_pkg::ADDR_W-1:0]        paddr,
  input  wire  [vgvq_pkg::DATA_W-1:0]        pwdata,
  output logic [vgvq_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);
  import vgvq_pkg::*;

  localparam int PLANE  = MAX_X * MAX_Y;
  localparam int DEPTH  = 3 * PLANE;
  localparam int MEM_AW = $clog2(DEPTH);

  logic [CFG_W-1:0]  size_x_r, size_y_r, size_z_r;
  logic [INV_W-1:0]  inv_r;
  logic [SIZE_W-1:0] sx, sy, sz;
  logic [LAG_W-1:0]  lag_r;
  logic              wr_cfg, restart;
  reg_idx_t          ridx;

  assign pready = 1'b1;
  assign wr_cfg = psel && penable && pwrite;
  assign ridx   = reg_idx_t'(paddr[3:2]);
  assign restart = wr_cfg && (ridx != REG_INV_TWO_DX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= CFG_W'(64);
      size_y_r <= CFG_W'(64);
      size_z_r <= CFG_W'(64);
      inv_r    <= INV_W'(8192);
    end else if (wr_cfg) begin
      case (ridx)
        REG_SIZE_X:     size_x_r <= pwdata[CFG_W-1:0];
        REG_SIZE_Y:     size_y_r <= pwdata[CFG_W-1:0];
        REG_SIZE_Z:     size_z_r <= pwdata[CFG_W-1:0];
        REG_INV_TWO_DX: inv_r    <= pwdata[INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_SIZE_X:     prdata = DATA_W'(size_x_r);
      REG_SIZE_Y:     prdata = DATA_W'(size_y_r);
      REG_SIZE_Z:     prdata = DATA_W'(size_z_r);
      REG_INV_TWO_DX: prdata = DATA_W'(inv_r);
      default:        prdata = '0;
    endcase
  end

  // sizes in use, clamped to 2..MAX_X, 2..MAX_Y and 1..MAX_Z
  always_comb begin
    if (SIZE_W'(size_x_r) < SIZE_W'(2)) begin
      sx = SIZE_W'(2);
    end else if (SIZE_W'(size_x_r) > SIZE_W'(MAX_X)) begin
      sx = SIZE_W'(MAX_X);
    end else begin
      sx = SIZE_W'(size_x_r);
    end
    if (SIZE_W'(size_y_r) < SIZE_W'(2)) begin
      sy = SIZE_W'(2);
    end else if (SIZE_W'(size_y_r) > SIZE_W'(MAX_Y)) begin
      sy = SIZE_W'(MAX_Y);
    end else begin
      sy = SIZE_W'(size_y_r);
    end
    if (SIZE_W'(size_z_r) < SIZE_W'(1)) begin
      sz = SIZE_W'(1);
    end else if (SIZE_W'(size_z_r) > SIZE_W'(MAX_Z)) begin
      sz = SIZE_W'(MAX_Z);
    end else begin
      sz = SIZE_W'(size_z_r);
    end
  end

  always_ff @(posedge clk) begin
    lag_r <= (sz > SIZE_W'(1)) ? LAG_W'(sx) * LAG_W'(sy) : LAG_W'(sx);
  end

  logic              st_wr_en, st_rd_en;
  logic [MEM_AW-1:0] st_wr_addr, st_rd_addr;
  logic [CELL_W-1:0] st_wr_data, st_rd_data;
  logic              push, pop, q_full, q_empty, back_idle;
  job_t              push_job, head_job;

  vgvq_front #(
    .MAX_X  (MAX_X),
    .MAX_Y  (MAX_Y),
    .MEM_AW (MEM_AW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (restart),
    .sx        (sx),
    .sy        (sy),
    .sz        (sz),
    .lag       (lag_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_kind),
    .in_vel_x  (in_vel_x),
    .in_vel_y  (in_vel_y),
    .in_vel_z  (in_vel_z),
    .wr_en     (st_wr_en),
    .wr_addr   (st_wr_addr),
    .wr_data   (st_wr_data),
    .push      (push),
    .push_job  (push_job),
    .q_full    (q_full),
    .q_empty   (q_empty),
    .back_idle (back_idle)
  );

  vgvq_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  vgvq_store #(
    .DEPTH  (DEPTH),
    .MEM_AW (MEM_AW)
  ) u_store (
    .clk       (clk),
    .wr_en     (st_wr_en),
    .wr_addr   (st_wr_addr),
    .wr_data   (st_wr_data),
    .rd_en     (st_rd_en),
    .rd_addr   (st_rd_addr),
    .rd_data_r (st_rd_data)
  );

  vgvq_back #(
    .MAX_X     (MAX_X),
    .MAX_Y     (MAX_Y),
    .MEM_AW    (MEM_AW),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .inv_two_dx     (inv_r),
    .job_avail      (!q_empty),
    .job            (head_job),
    .pop            (pop),
    .rd_en          (st_rd_en),
    .rd_addr        (st_rd_addr),
    .rd_data        (st_rd_data),
    .idle           (back_idle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_index (out_cell_index),
    .out_vort_x     (out_vort_x),
    .out_vort_y     (out_vort_y),
    .out_vort_z     (out_vort_z),
    .out_vel_mag    (out_vel_mag),
    .out_vort_mag   (out_vort_mag),
    .out_q_value    (out_q_value),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire
